// ===== hw/rtl/psl_pkg.sv =====
// Package for the per-source connection limiter.
// Holds the shared types, codes and field widths; used by every module of the block.
package psl_pkg;

   localparam int ADDR_W  = 32;
   localparam int TAG_W   = 16;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 9;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TOTAL      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PER_SOURCE = 1'd1;

   typedef enum logic {
      OP_OPEN  = 1'b0,
      OP_CLOSE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_ADMIT  = 2'd0,
      VERDICT_TOTAL  = 2'd1,
      VERDICT_SOURCE = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_ADDR_FULL   = 2'd1,
      ERR_TAG_FULL    = 2'd2,
      ERR_UNKNOWN_TAG = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ASCAN,
      S_TSCAN,
      S_UPDATE,
      S_OUT
   } state_type;

   // Classified command handed from the front queue to the engine.
   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  addr;
      logic [TAG_W-1:0]   tag;
   } cmd_type;

   // Result item as produced by the engine.
   typedef struct packed {
      verdict_type        verdict;
      error_type          error;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] src;
   } res_type;

endpackage

// ===== hw/rtl/psl_if.sv =====
// Channel interfaces of the per-source connection limiter.
// Request and result channels with valid/ready handshake; depend on nothing else.
interface psl_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] source_address;
   logic [15:0] connection_tag;

   modport source (output valid, kind, source_address, connection_tag, input ready);
   modport sink   (input valid, kind, source_address, connection_tag, output ready);
endinterface

interface psl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [1:0] error;
   logic [8:0] total_count;
   logic [8:0] source_count;

   modport source (output valid, verdict, error, total_count, source_count, input ready);
   modport sink   (input valid, verdict, error, total_count, source_count, output ready);
endinterface

// ===== hw/rtl/psl_front.sv =====
// Front part of the limiter: accepts request items, classifies them and queues them.
// Depends on psl_pkg and psl_if.
module psl_front (
   input  logic              clock,
   input  logic              reset,
   psl_req_if.sink           req_ch,
   input  logic              busy_clear,
   output logic              cmd_valid,
   output psl_pkg::cmd_type  cmd,
   input  logic              cmd_ready
);
   import psl_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   cmd_type    new_cmd;

   // No items are taken while the tables are being cleared.
   assign req_ch.ready = (cnt_ff != 2'd2) && !busy_clear;
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = cmd_valid && cmd_ready;

   // Classify the item by its kind bit.
   always_comb begin
      new_cmd.op   = req_ch.kind ? OP_CLOSE : OP_OPEN;
      new_cmd.addr = req_ch.source_address;
      new_cmd.tag  = req_ch.connection_tag;
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hw/rtl/psl_engine.sv =====
// Back part of the limiter: address and tag tables, scan sequencer and result register.
// Depends on psl_pkg.
module psl_engine #(
   parameter int ADDRESS_ENTRIES = 256,
   parameter int TAG_ENTRIES     = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  psl_pkg::cmd_type              cmd,
   output logic                          cmd_ready,
   output logic                          busy_clear,
   input  logic [psl_pkg::LIMIT_W-1:0]   max_total,
   input  logic [psl_pkg::LIMIT_W-1:0]   max_per_source,
   output logic                          res_valid,
   output psl_pkg::res_type              res,
   input  logic                          res_ready
);
   import psl_pkg::*;

   localparam int AW   = (ADDRESS_ENTRIES > 1) ? $clog2(ADDRESS_ENTRIES) : 1;
   localparam int TW   = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
   localparam int IW   = ((AW > TW) ? AW : TW) + 1;
   localparam int CW   = $clog2(TAG_ENTRIES + 1);
   localparam int MAXE = (ADDRESS_ENTRIES > TAG_ENTRIES) ? ADDRESS_ENTRIES : TAG_ENTRIES;

   // Table memories.
   logic [ADDR_W-1:0] a_key_mem [ADDRESS_ENTRIES];
   logic [CW-1:0]     a_cnt_mem [ADDRESS_ENTRIES];
   logic [TAG_W-1:0]  t_key_mem [TAG_ENTRIES];
   logic [ADDR_W-1:0] t_addr_mem [TAG_ENTRIES];
   logic              t_vld_mem [TAG_ENTRIES];

   logic [ADDR_W-1:0] a_key_rd_ff;
   logic [CW-1:0]     a_cnt_rd_ff;
   logic [TAG_W-1:0]  t_key_rd_ff;
   logic [ADDR_W-1:0] t_addr_rd_ff;
   logic              t_vld_rd_ff;

   // Memory write controls.
   logic              a_we, t_we;
   logic [AW-1:0]     a_waddr;
   logic [TW-1:0]     t_waddr;
   logic [ADDR_W-1:0] a_wkey, t_waddr_val;
   logic [CW-1:0]     a_wcnt;
   logic [TAG_W-1:0]  t_wkey;
   logic              t_wvld;

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              chk_ff, chk_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [AW-1:0]     a_idx_ff, a_idx_in;
   logic [CW-1:0]     a_cnt_ff, a_cnt_in;
   logic              a_hit_ff, a_hit_in;
   logic              free_ff, free_in;
   logic [TW-1:0]     t_idx_ff, t_idx_in;
   logic [CW-1:0]     total_ff, total_in;
   verdict_type       verdict_ff, verdict_in;
   error_type         error_ff, error_in;
   logic [CW-1:0]     src_ff, src_in;
   logic              out_vld_ff, out_vld_in;
   res_type           out_ff, out_in;

   logic              a_occ, a_match, t_match, a_done, t_done;

   assign busy_clear = (state_ff == S_CLEAR);
   assign res_valid  = out_vld_ff;
   assign res        = out_ff;

   assign a_occ   = (a_cnt_rd_ff != '0);
   assign a_match = chk_ff && a_occ && (a_key_rd_ff == key_ff);
   assign t_match = chk_ff && ((op_ff == OP_OPEN) ? !t_vld_rd_ff
                                : (t_vld_rd_ff && (t_key_rd_ff == tag_ff)));
   assign a_done  = !chk_ff && (idx_ff >= IW'(ADDRESS_ENTRIES));
   assign t_done  = !chk_ff && (idx_ff >= IW'(TAG_ENTRIES));

   // Next state, scan control and table writes.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      chk_in      = 1'b0;
      chk_idx_in  = idx_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      tag_in      = tag_ff;
      a_idx_in    = a_idx_ff;
      a_cnt_in    = a_cnt_ff;
      a_hit_in    = a_hit_ff;
      free_in     = free_ff;
      t_idx_in    = t_idx_ff;
      total_in    = total_ff;
      verdict_in  = verdict_ff;
      error_in    = error_ff;
      src_in      = src_ff;
      out_vld_in  = out_vld_ff && !res_ready;
      out_in      = out_ff;
      cmd_ready   = 1'b0;
      a_we        = 1'b0;
      t_we        = 1'b0;
      a_waddr     = a_idx_ff;
      t_waddr     = t_idx_ff;
      a_wkey      = key_ff;
      a_wcnt      = '0;
      t_wkey      = tag_ff;
      t_waddr_val = key_ff;
      t_wvld      = 1'b0;

      case (state_ff)
         // Sweep both tables after reset: every address entry free, every tag invalid.
         S_CLEAR: begin
            a_we    = idx_ff < IW'(ADDRESS_ENTRIES);
            t_we    = idx_ff < IW'(TAG_ENTRIES);
            a_waddr = idx_ff[AW-1:0];
            t_waddr = idx_ff[TW-1:0];
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == IW'(MAXE - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in    = cmd.op;
               key_in   = cmd.addr;
               tag_in   = cmd.tag;
               idx_in   = '0;
               free_in  = 1'b0;
               a_hit_in = 1'b0;
               a_cnt_in = '0;
               state_in = (cmd.op == OP_OPEN) ? S_ASCAN : S_TSCAN;
            end
         end

         // Address table scan: one read issued per cycle, its data checked in the cycle after.
         S_ASCAN: begin
            if (idx_ff < IW'(ADDRESS_ENTRIES)) begin
               chk_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (a_match) begin
               a_idx_in = chk_idx_ff[AW-1:0];
               a_cnt_in = a_cnt_rd_ff;
               a_hit_in = 1'b1;
               chk_in   = 1'b0;
               idx_in   = '0;
               state_in = (op_ff == OP_OPEN) ? S_TSCAN : S_UPDATE;
            end else if (a_done) begin
               chk_in = 1'b0;
               idx_in = '0;
               if (op_ff == OP_CLOSE) begin
                  state_in = S_UPDATE;
               end else if (free_ff) begin
                  state_in = S_TSCAN;
               end else begin
                  verdict_in = VERDICT_ADMIT;
                  error_in   = ERR_ADDR_FULL;
                  src_in     = '0;
                  state_in   = S_OUT;
               end
            end else if (chk_ff && !a_occ && !free_ff) begin
               // Remember the lowest free entry for a new address.
               free_in  = 1'b1;
               a_idx_in = chk_idx_ff[AW-1:0];
               a_cnt_in = '0;
            end
         end

         // Tag table scan: lowest free entry on open, lowest matching entry on close.
         S_TSCAN: begin
            if (idx_ff < IW'(TAG_ENTRIES)) begin
               chk_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (t_match) begin
               t_idx_in = chk_idx_ff[TW-1:0];
               chk_in   = 1'b0;
               idx_in   = '0;
               if (op_ff == OP_CLOSE) begin
                  key_in   = t_addr_rd_ff;
                  state_in = S_ASCAN;
               end else begin
                  state_in = S_UPDATE;
               end
            end else if (t_done) begin
               chk_in     = 1'b0;
               idx_in     = '0;
               verdict_in = VERDICT_ADMIT;
               if (op_ff == OP_OPEN) begin
                  error_in = ERR_TAG_FULL;
                  src_in   = a_cnt_ff;
               end else begin
                  error_in = ERR_UNKNOWN_TAG;
                  src_in   = '0;
               end
               state_in = S_OUT;
            end
         end

         // Commit the counts and the tag entry, then judge the limits on an open.
         S_UPDATE: begin
            error_in   = ERR_NONE;
            verdict_in = VERDICT_ADMIT;
            t_we       = 1'b1;
            if (op_ff == OP_OPEN) begin
               a_we     = 1'b1;
               a_wcnt   = a_cnt_ff + 1'b1;
               t_wvld   = 1'b1;
               total_in = total_ff + 1'b1;
               src_in   = a_cnt_ff + 1'b1;
               if ((max_total != '0) && (32'(total_in) > 32'(max_total))) begin
                  verdict_in = VERDICT_TOTAL;
               end else if ((max_per_source != '0) &&
                            (32'(src_in) > 32'(max_per_source))) begin
                  verdict_in = VERDICT_SOURCE;
               end
            end else begin
               t_wvld = 1'b0;
               if (a_hit_ff) begin
                  a_we   = 1'b1;
                  a_wcnt = a_cnt_ff - 1'b1;
                  src_in = a_cnt_ff - 1'b1;
               end else begin
                  src_in = '0;
               end
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
            end
            state_in = S_OUT;
         end

         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!out_vld_ff || res_ready) begin
               out_vld_in     = 1'b1;
               out_in.verdict = verdict_ff;
               out_in.error   = error_ff;
               out_in.total   = COUNT_W'(total_ff);
               out_in.src     = COUNT_W'(src_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         chk_ff     <= 1'b0;
         total_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         chk_ff     <= chk_in;
         total_ff   <= total_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      tag_ff     <= tag_in;
      a_idx_ff   <= a_idx_in;
      a_cnt_ff   <= a_cnt_in;
      a_hit_ff   <= a_hit_in;
      free_ff    <= free_in;
      t_idx_ff   <= t_idx_in;
      verdict_ff <= verdict_in;
      error_ff   <= error_in;
      src_ff     <= src_in;
      out_ff     <= out_in;
   end

   // Address table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_key_mem[a_waddr] <= a_wkey;
         a_cnt_mem[a_waddr] <= a_wcnt;
      end
      a_key_rd_ff <= a_key_mem[idx_ff[AW-1:0]];
      a_cnt_rd_ff <= a_cnt_mem[idx_ff[AW-1:0]];
   end

   // Tag table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (t_we) begin
         t_key_mem[t_waddr]  <= t_wkey;
         t_addr_mem[t_waddr] <= t_waddr_val;
         t_vld_mem[t_waddr]  <= t_wvld;
      end
      t_key_rd_ff  <= t_key_mem[idx_ff[TW-1:0]];
      t_addr_rd_ff <= t_addr_mem[idx_ff[TW-1:0]];
      t_vld_rd_ff  <= t_vld_mem[idx_ff[TW-1:0]];
   end

endmodule

// ===== hw/rtl/per_source_connection_limiter.sv =====
// Top level of the per-source connection limiter.
// Depends on psl_pkg, psl_if, psl_front and psl_engine.
//
// Usage:
// The req channel takes one item per connection event: kind 0 opens a
// connection from source_address under connection_tag, kind 1 closes the
// connection with that tag. The rsp channel returns exactly one item per
// request, in order, with the verdict, an error code, the total open count
// and the count of the item's address.
// The csr port sets the total and per-address limits (0 disables a check);
// write it only while no item is in flight.
// Each item scans one or both tables linearly, one entry per cycle through
// a single read port per table, and one item is processed at a time.
// A two-entry queue takes new items while a result waits in the output
// register; a stalled rsp channel holds its result and the queue fills.
// After reset the block clears both tables and holds req ready low meanwhile.
module per_source_connection_limiter #(
   parameter int ADDRESS_ENTRIES = 256,
   parameter int TAG_ENTRIES     = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   psl_req_if.sink                         req_ch,
   psl_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [psl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psl_pkg::LIMIT_W-1:0]     csr_write_data
);
   import psl_pkg::*;

   logic               busy_clear;
   logic               cmd_valid, cmd_ready;
   cmd_type            cmd;
   logic               res_valid;
   res_type            res;
   logic [LIMIT_W-1:0] max_total_ff, max_total_in;
   logic [LIMIT_W-1:0] max_per_source_ff, max_per_source_in;

   // Limit registers.
   always_comb begin
      max_total_in      = max_total_ff;
      max_per_source_in = max_per_source_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_TOTAL:      max_total_in      = csr_write_data;
            CSR_MAX_PER_SOURCE: max_per_source_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff      <= '0;
         max_per_source_ff <= '0;
      end else begin
         max_total_ff      <= max_total_in;
         max_per_source_ff <= max_per_source_in;
      end
   end

   psl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .busy_clear (busy_clear),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   psl_engine #(
      .ADDRESS_ENTRIES (ADDRESS_ENTRIES),
      .TAG_ENTRIES     (TAG_ENTRIES)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready),
      .busy_clear     (busy_clear),
      .max_total      (max_total_ff),
      .max_per_source (max_per_source_ff),
      .res_valid      (res_valid),
      .res            (res),
      .res_ready      (rsp_ch.ready)
   );

   // Result channel.
   assign rsp_ch.valid        = res_valid;
   assign rsp_ch.verdict      = res.verdict;
   assign rsp_ch.error        = res.error;
   assign rsp_ch.total_count  = res.total;
   assign rsp_ch.source_count = res.src;

   // A limit verdict only comes with a successful open.
   a_verdict_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.verdict != VERDICT_ADMIT)) |-> (rsp_ch.error == ERR_NONE))
      else $error("limit verdict reported together with an error");

   // An unknown tag reports no address count.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.error == ERR_UNKNOWN_TAG)) |-> (rsp_ch.source_count == '0))
      else $error("unknown tag reported a nonzero source count");

   // A total-limit verdict needs an enabled total limit.
   a_total_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.verdict == VERDICT_TOTAL)) |-> (max_total_ff != '0))
      else $error("total limit verdict while the total limit is disabled");

endmodule

// ===== bench/tb_per_source_connection_limiter.sv =====
// Self-checking testbench for the per-source connection limiter.
// Depends on psl_pkg, psl_if and the per_source_connection_limiter RTL.
// Runs a directed table, random phases under several limit settings, then a table fill.
module tb_per_source_connection_limiter;
   import psl_pkg::*;

   localparam int NUM_ADDR = 256;
   localparam int NUM_TAG  = 256;

   // One row of the directed table; has_exp marks a hand-typed result.
   typedef struct {
      op_type             op;
      logic [31:0]        addr;
      logic [15:0]        tag;
      bit                 has_exp;
      verdict_type        verdict;
      error_type          error;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] src;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]   csr_write_data;

   psl_req_if req_ch ();
   psl_rsp_if rsp_ch ();

   per_source_connection_limiter dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state.
   logic [15:0] lim_total, lim_source;
   int          conn_total;
   logic [31:0] addr_key [NUM_ADDR];
   int          addr_cnt [NUM_ADDR];
   logic [15:0] tag_key  [NUM_TAG];
   logic [31:0] tag_addr [NUM_TAG];
   bit          tag_used [NUM_TAG];

   res_type     pending_results [$];
   logic [15:0] open_tags [$];
   int          fail_count;
   int          items_sent;
   int          results_seen;
   bit          no_idle;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #80_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Works out the result of one item and updates the predicted tables.
   function automatic res_type predict_limit(op_type op, logic [31:0] addr,
                                             logic [15:0] tag);
      res_type r;
      int a, t;
      r.verdict = VERDICT_ADMIT;
      r.error = ERR_NONE;
      r.src = '0;
      a = -1;
      t = -1;
      if (op == OP_OPEN) begin
         for (int i = 0; i < NUM_ADDR; i++)
            if (a < 0 && addr_cnt[i] != 0 && addr_key[i] == addr) a = i;
         if (a < 0) begin
            for (int i = 0; i < NUM_ADDR; i++)
               if (a < 0 && addr_cnt[i] == 0) a = i;
            if (a < 0) r.error = ERR_ADDR_FULL;
         end else begin
            r.src = COUNT_W'(addr_cnt[a]);
         end
         if (r.error == ERR_NONE) begin
            for (int i = 0; i < NUM_TAG; i++)
               if (t < 0 && !tag_used[i]) t = i;
            if (t < 0) begin
               r.error = ERR_TAG_FULL;
            end else begin
               addr_key[a] = addr;
               addr_cnt[a]++;
               conn_total++;
               tag_key[t] = tag;
               tag_addr[t] = addr;
               tag_used[t] = 1'b1;
               r.src = COUNT_W'(addr_cnt[a]);
               if (lim_total != 0 && conn_total > lim_total)
                  r.verdict = VERDICT_TOTAL;
               else if (lim_source != 0 && addr_cnt[a] > lim_source)
                  r.verdict = VERDICT_SOURCE;
            end
         end
      end else begin
         for (int i = 0; i < NUM_TAG; i++)
            if (t < 0 && tag_used[i] && tag_key[i] == tag) t = i;
         if (t < 0) begin
            r.error = ERR_UNKNOWN_TAG;
         end else begin
            for (int i = 0; i < NUM_ADDR; i++)
               if (a < 0 && addr_cnt[i] != 0 && addr_key[i] == tag_addr[t]) a = i;
            if (a >= 0) begin
               addr_cnt[a]--;
               r.src = COUNT_W'(addr_cnt[a]);
            end
            if (conn_total != 0) conn_total--;
            tag_used[t] = 1'b0;
         end
      end
      r.total = COUNT_W'(conn_total);
      return r;
   endfunction

   // Sends one item after a random gap and records its expected result.
   task automatic send_item(op_type op, logic [31:0] addr, logic [15:0] tag,
                            bit has_exp = 0, res_type typed = '0);
      int gap;
      res_type r;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= op;
      req_ch.source_address <= addr;
      req_ch.connection_tag <= tag;
      do @(posedge clock); while (!req_ch.ready);
      r = predict_limit(op, addr, tag);
      pending_results.push_back(has_exp ? typed : r);
      items_sent++;
   endtask

   // Waits for every expected result, then lets the block settle.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes one limit register; no item is in flight here.
   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MAX_TOTAL) lim_total = value;
      else lim_source = value;
   endtask

   // Result side: random stalls, then a field-by-field check.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         res_type want;
         int s;
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item with no expectation waiting");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_ch.verdict);
               fail_count++;
            end
            if (rsp_ch.error !== want.error) begin
               $error("error: expected %0d, got %0d", want.error, rsp_ch.error);
               fail_count++;
            end
            if (rsp_ch.total_count !== want.total) begin
               $error("total_count: expected %0d, got %0d", want.total,
                      rsp_ch.total_count);
               fail_count++;
            end
            if (rsp_ch.source_count !== want.src) begin
               $error("source_count: expected %0d, got %0d", want.src,
                      rsp_ch.source_count);
               fail_count++;
            end
         end
         s = no_idle ? 0 : $urandom_range(0, 6);
         stall_left <= (s > 0) ? s - 1 : 0;
         if (s > 0) rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready) begin
         if (stall_left == 0) rsp_ch.ready <= 1'b1;
         else stall_left <= stall_left - 1;
      end
   end

   // Directed table: boundary values, duplicate tags, both limits, unknown tag.
   dir_row_type dir_rows [14] = '{
      '{OP_CLOSE, 32'h0,        16'h0005, 1, VERDICT_ADMIT,  ERR_UNKNOWN_TAG, 9'd0, 9'd0},
      '{OP_OPEN,  32'h0,        16'h0000, 1, VERDICT_ADMIT,  ERR_NONE,        9'd1, 9'd1},
      '{OP_OPEN,  32'h0,        16'hFFFF, 1, VERDICT_ADMIT,  ERR_NONE,        9'd2, 9'd2},
      '{OP_OPEN,  32'h0,        16'h0000, 1, VERDICT_SOURCE, ERR_NONE,        9'd3, 9'd3},
      '{OP_OPEN,  32'hFFFFFFFF, 16'h0001, 1, VERDICT_TOTAL,  ERR_NONE,        9'd4, 9'd1},
      '{OP_CLOSE, 32'hFFFFFFFF, 16'h0000, 1, VERDICT_ADMIT,  ERR_NONE,        9'd3, 9'd2},
      '{OP_CLOSE, 32'h0,        16'h0000, 1, VERDICT_ADMIT,  ERR_NONE,        9'd2, 9'd1},
      '{OP_CLOSE, 32'h0,        16'h0000, 1, VERDICT_ADMIT,  ERR_UNKNOWN_TAG, 9'd2, 9'd0},
      '{OP_CLOSE, 32'h0,        16'hFFFF, 1, VERDICT_ADMIT,  ERR_NONE,        9'd1, 9'd0},
      '{OP_CLOSE, 32'h12345678, 16'h0001, 1, VERDICT_ADMIT,  ERR_NONE,        9'd0, 9'd0},
      '{OP_OPEN,  32'hA5A5A5A5, 16'h8000, 0, VERDICT_ADMIT,  ERR_NONE,        9'd0, 9'd0},
      '{OP_OPEN,  32'h5A5A5A5A, 16'h7FFF, 0, VERDICT_ADMIT,  ERR_NONE,        9'd0, 9'd0},
      '{OP_CLOSE, 32'hFFFFFFFF, 16'h8000, 0, VERDICT_ADMIT,  ERR_NONE,        9'd0, 9'd0},
      '{OP_CLOSE, 32'h0,        16'h7FFF, 0, VERDICT_ADMIT,  ERR_NONE,        9'd0, 9'd0}
   };

   // Limit settings for the random phases: total, per address.
   logic [15:0] phase_limits [6][2] = '{
      '{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF}, '{16'd5, 16'd3},
      '{16'd1, 16'd1}, '{16'd40, 16'd0}, '{16'd0, 16'd2}
   };

   // Main sequence.
   initial begin
      res_type typed;
      logic [31:0] addr_pool [8];
      logic [31:0] addr;
      logic [15:0] tag;
      int k;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_TOTAL;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = OP_OPEN;
      req_ch.source_address = '0;
      req_ch.connection_tag = '0;
      fail_count = 0;
      items_sent = 0;
      results_seen = 0;
      no_idle = 1'b0;
      lim_total = '0;
      lim_source = '0;
      conn_total = 0;
      for (int i = 0; i < NUM_ADDR; i++) addr_cnt[i] = 0;
      for (int i = 0; i < NUM_TAG; i++) tag_used[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under a total limit of 3 and a per-address limit of 2.
      write_limit(CSR_MAX_TOTAL, 16'd3);
      write_limit(CSR_MAX_PER_SOURCE, 16'd2);
      foreach (dir_rows[i]) begin
         typed.verdict = dir_rows[i].verdict;
         typed.error = dir_rows[i].error;
         typed.total = dir_rows[i].total;
         typed.src = dir_rows[i].src;
         send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].tag,
                   dir_rows[i].has_exp, typed);
      end
      drain_results();

      // Random phases: mostly opens from a small address pool and closes of
      // known tags, with some stray addresses and unknown tags mixed in.
      for (int p = 0; p < 6; p++) begin
         write_limit(CSR_MAX_TOTAL, phase_limits[p][0]);
         write_limit(CSR_MAX_PER_SOURCE, phase_limits[p][1]);
         no_idle = (p == 2);
         foreach (addr_pool[i]) addr_pool[i] = $urandom;
         for (int n = 0; n < 32; n++) begin
            if (open_tags.size() > 0 && $urandom_range(0, 99) < 45) begin
               if ($urandom_range(0, 9) == 0) begin
                  tag = 16'($urandom);
               end else begin
                  k = $urandom_range(0, open_tags.size() - 1);
                  tag = open_tags[k];
                  open_tags.delete(k);
               end
               send_item(OP_CLOSE, $urandom, tag);
            end else begin
               addr = ($urandom_range(0, 3) == 0) ? $urandom
                                                  : addr_pool[3'($urandom_range(0, 7))];
               tag = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7))
                                                 : 16'($urandom);
               open_tags.push_back(tag);
               send_item(OP_OPEN, addr, tag);
            end
         end
         // Close what is still open so each phase starts near empty.
         while (open_tags.size() > 0) send_item(OP_CLOSE, $urandom, open_tags.pop_front());
         drain_results();
      end

      // Fill both tables, then hit the address-full and tag-full errors.
      write_limit(CSR_MAX_TOTAL, 16'd200);
      write_limit(CSR_MAX_PER_SOURCE, 16'd0);
      no_idle = 1'b0;
      for (int i = 0; i < NUM_ADDR; i++) begin
         addr = {16'($urandom_range(0, 16'hFFFF)), 8'h00, i[7:0]};
         addr_pool[i % 8] = addr;
         tag = 16'(i);
         open_tags.push_back(tag);
         send_item(OP_OPEN, addr, tag);
      end
      send_item(OP_OPEN, 32'hFFFF_FF00, 16'h1234);
      send_item(OP_OPEN, addr_pool[3], 16'h4321);
      send_item(OP_CLOSE, 32'h0, 16'hFFFF);
      while (open_tags.size() > 0) begin
         k = $urandom_range(0, open_tags.size() - 1);
         send_item(OP_CLOSE, $urandom, open_tags[k]);
         open_tags.delete(k);
      end
      drain_results();

      $display("Sent %0d items and checked %0d results over eight limit settings,",
               items_sent, results_seen);
      $display("including limit hits, duplicate tags and both full-table errors.");
      if (fail_count == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== per_source_connection_limiter.f =====
hw/rtl/psl_pkg.sv
hw/rtl/psl_if.sv
hw/rtl/psl_front.sv
hw/rtl/psl_engine.sv
hw/rtl/per_source_connection_limiter.sv
bench/tb_per_source_connection_limiter.sv
